>>> rtl/mts_pkg.sv
package mts_pkg;

  localparam int VAL_W         = 32;
  localparam int OCC_W         = 7;
  localparam int DEFAULT_DEPTH = 64;

  // Request codes
  localparam logic [1:0] REQ_PUSH    = 2'd0;
  localparam logic [1:0] REQ_POP     = 2'd1;
  localparam logic [1:0] REQ_POP_MAX = 2'd2;
  localparam logic [1:0] REQ_QUERY   = 2'd3;

  // Status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]              req_type;
    logic signed [VAL_W-1:0] push_value;
  } cmd_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] removed_value;
    logic signed [VAL_W-1:0] top_value;
    logic signed [VAL_W-1:0] max_value;
    logic [OCC_W-1:0]        occupancy;
    logic                    is_empty;
    logic [1:0]              status;
  } result_t;

  // One stack entry as it moves along the chain: its value and the
  // largest value from this entry down to the bottom.
  typedef struct packed {
    logic signed [VAL_W-1:0] val;
    logic signed [VAL_W-1:0] rmax;
  } link_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_PUSH,
    OP_POP,
    OP_ARM,
    OP_SEEK,
    OP_REMOVE,
    OP_SETTLE
  } cell_op_t;

  typedef struct packed {
    cell_op_t                op;
    logic signed [VAL_W-1:0] max_value;
  } cell_ctl_t;

endpackage

>>> rtl/mts_cell.sv
module mts_cell (
  input  logic              clk,
  input  logic              rst,
  input  mts_pkg::cell_ctl_t ctl,
  input  mts_pkg::link_t    above,
  input  mts_pkg::link_t    below,
  input  logic              below_valid,
  input  logic              tok_in,
  output mts_pkg::link_t    cur,
  output logic              tok_out,
  output logic              found
);

  mts_pkg::link_t q;
  logic           tok;
  logic           seen;
  logic           match;

  assign match   = (q.val == ctl.max_value);
  assign found   = tok & match;
  assign tok_out = tok & ~match;
  assign cur     = q;

  // Search token and the mark left behind once it passes.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok  <= 1'b0;
      seen <= 1'b0;
    end else begin
      unique case (ctl.op)
        mts_pkg::OP_ARM: begin
          tok  <= tok_in;
          seen <= 1'b0;
        end
        mts_pkg::OP_SEEK: begin
          tok <= tok_in;
          if (tok_out) begin
            seen <= 1'b1;
          end
        end
        mts_pkg::OP_REMOVE: begin
          tok <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Entry payload: shift, close the gap, or refresh the running maximum.
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      mts_pkg::OP_PUSH: begin
        q <= above;
      end
      mts_pkg::OP_POP: begin
        q <= below;
      end
      mts_pkg::OP_REMOVE: begin
        if (!seen) begin
          q <= below;
        end
      end
      mts_pkg::OP_SETTLE: begin
        q.rmax <= (below_valid && (below.rmax > q.val)) ? below.rmax : q.val;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/max_tracking_stack_unit.sv
// Bounded stack of signed 32-bit values that tracks its maximum.
//
// Command channel: present cmd with start high; the beat is taken at a
// rising edge where start is high and busy is low. req_type selects push,
// pop top, pop maximum or query. One result beat follows every command:
// done is high for exactly one cycle with result valid; the receiver cannot
// stall, so capture result whenever done is high.
//
// Storage is a row of STACK_DEPTH identical cells, top at cell 0. Each cell
// holds an entry and the running maximum from itself down to the bottom,
// so the stack maximum is always in cell 0.
// Push, pop, query and any flagged request go straight to the result beat.
// Pop maximum first walks a token down the chain one cell a cycle to find
// the topmost entry equal to the maximum, then the running maxima above it
// are rebuilt one cell a cycle.
// A new command may be taken in the same cycle that done is high.
// Reset empties the stack and drops any command in flight; cell contents
// are not cleared, only the occupancy count.
module max_tracking_stack_unit #(
  parameter int STACK_DEPTH = mts_pkg::DEFAULT_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  mts_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             done,
  output mts_pkg::result_t result
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int IW = $clog2(STACK_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEEK,
    S_REMOVE,
    S_SETTLE,
    S_REPORT
  } state_t;

  state_t  state;
  logic [CW-1:0] cnt;
  logic [IW-1:0] idx;
  logic signed [mts_pkg::VAL_W-1:0] removed;
  logic [1:0] status;

  mts_pkg::cell_ctl_t ctl;
  mts_pkg::link_t     head;
  mts_pkg::link_t     cur     [STACK_DEPTH];
  logic [STACK_DEPTH-1:0] tok_out;
  logic [STACK_DEPTH-1:0] found;
  logic               any_found;
  logic               full;
  logic               empty;

  assign full      = (cnt == CW'(STACK_DEPTH));
  assign empty     = (cnt == '0);
  assign any_found = |found;
  assign busy      = (state != S_IDLE);

  // New top entry for a push: its running max folds in the old maximum.
  assign head.val  = cmd.push_value;
  assign head.rmax = (!empty && (cur[0].rmax > cmd.push_value)) ? cur[0].rmax
                                                                : cmd.push_value;

  // Decode the chain operation for this cycle.
  always_comb begin
    ctl.op        = mts_pkg::OP_HOLD;
    ctl.max_value = cur[0].rmax;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          case (cmd.req_type)
            mts_pkg::REQ_PUSH:    if (!full)  ctl.op = mts_pkg::OP_PUSH;
            mts_pkg::REQ_POP:     if (!empty) ctl.op = mts_pkg::OP_POP;
            mts_pkg::REQ_POP_MAX: if (!empty) ctl.op = mts_pkg::OP_ARM;
            default: begin
            end
          endcase
        end
      end
      S_SEEK:   ctl.op = mts_pkg::OP_SEEK;
      S_REMOVE: ctl.op = mts_pkg::OP_REMOVE;
      S_SETTLE: ctl.op = mts_pkg::OP_SETTLE;
      S_REPORT: ctl.op = mts_pkg::OP_HOLD;
      default:  ctl.op = mts_pkg::OP_HOLD;
    endcase
  end

  // The cell row: each cell sees its upper and lower neighbor.
  for (genvar j = 0; j < STACK_DEPTH; j++) begin : g_cell
    mts_pkg::link_t above;
    mts_pkg::link_t below;
    logic           tok_in;

    if (j == 0) begin : g_first
      assign above  = head;
      assign tok_in = (ctl.op == mts_pkg::OP_ARM);
    end else begin : g_mid
      assign above  = cur[j-1];
      assign tok_in = tok_out[j-1];
    end

    if (j == STACK_DEPTH - 1) begin : g_last
      assign below = '0;
    end else begin : g_inner
      assign below = cur[j+1];
    end

    mts_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .above       (above),
      .below       (below),
      .below_valid (cnt > CW'(j + 1)),
      .tok_in      (tok_in),
      .cur         (cur[j]),
      .tok_out     (tok_out[j]),
      .found       (found[j])
    );
  end

  // Sequencer: occupancy, removal bookkeeping and the result beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            removed <= '0;
            status  <= mts_pkg::STAT_OK;
            idx     <= '0;
            state   <= S_REPORT;
            case (cmd.req_type)
              mts_pkg::REQ_PUSH: begin
                if (full) begin
                  status <= mts_pkg::STAT_FULL;
                end else begin
                  cnt <= cnt + CW'(1);
                end
              end
              mts_pkg::REQ_POP: begin
                if (empty) begin
                  status <= mts_pkg::STAT_EMPTY;
                end else begin
                  cnt     <= cnt - CW'(1);
                  removed <= cur[0].val;
                end
              end
              mts_pkg::REQ_POP_MAX: begin
                if (empty) begin
                  status <= mts_pkg::STAT_EMPTY;
                end else begin
                  // The removed entry is the current maximum by definition.
                  removed <= cur[0].rmax;
                  state   <= S_SEEK;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_SEEK: begin
          // Advance the token until a cell holding the maximum sees it.
          if (any_found) begin
            state <= S_REMOVE;
          end else begin
            idx <= idx + IW'(1);
          end
        end
        S_REMOVE: begin
          cnt <= cnt - CW'(1);
          if (idx == '0) begin
            state <= S_REPORT;
          end else begin
            state <= S_SETTLE;
          end
        end
        S_SETTLE: begin
          // One cell above the gap regains its running max per cycle.
          idx <= idx - IW'(1);
          if (idx == IW'(1)) begin
            state <= S_REPORT;
          end
        end
        S_REPORT: begin
          done                 <= 1'b1;
          result.removed_value <= removed;
          result.top_value     <= empty ? '0 : cur[0].val;
          result.max_value     <= empty ? '0 : cur[0].rmax;
          result.occupancy     <= mts_pkg::OCC_W'(cnt);
          result.is_empty      <= empty;
          result.status        <= status;
          state                <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/mts_checker.sv
module mts_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input mts_pkg::result_t result
);

  // An accepted command keeps the unit busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  // A result beat arrives only once the unit is ready again.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while busy");

  // An empty stack reports zero top and maximum.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.is_empty) |-> (result.top_value == '0 && result.max_value == '0))
    else $error("empty stack reported nonzero top or maximum");

  // A flagged request removes nothing.
  a_flag_removed: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != mts_pkg::STAT_OK) |-> (result.removed_value == '0))
    else $error("flagged request reported a removed value");

  // The maximum is never below the top entry.
  a_max_ge_top: assert property (@(posedge clk) disable iff (rst)
    (done && !result.is_empty) |-> (result.max_value >= result.top_value))
    else $error("maximum below top entry");

endmodule

bind max_tracking_stack_unit mts_checker u_mts_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

>>> tb/tb_max_tracking_stack_unit.sv
`timescale 1ns / 1ps

module tb_max_tracking_stack_unit;

  localparam int STACK_DEPTH = mts_pkg::DEFAULT_DEPTH;
  localparam int ITEM_TARGET = 1050;
  localparam int CYCLE_LIMIT = 1_000_000;
  // Longest pop maximum walks the whole chain and back.
  localparam int SETTLE_CYCLES = 2 * STACK_DEPTH + 8;
  localparam int REPORT_LIMIT = 10;

  localparam logic signed [mts_pkg::VAL_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
  localparam logic signed [mts_pkg::VAL_W-1:0] NEG_LIMIT = 32'h8000_0000;

  // Results that can be read at a glance for an empty stack.
  localparam mts_pkg::result_t EMPTY_FLAGGED =
    '{32'sd0, 32'sd0, 32'sd0, 7'd0, 1'b1, mts_pkg::STAT_EMPTY};
  localparam mts_pkg::result_t EMPTY_QUIET =
    '{32'sd0, 32'sd0, 32'sd0, 7'd0, 1'b1, mts_pkg::STAT_OK};

  // Random traffic mix: grow the stack, shrink it, or churn around a level.
  typedef enum logic [1:0] {
    MIX_FILL,
    MIX_DRAIN,
    MIX_CHURN
  } traffic_mix_t;

  // One directed beat; when check_typed is set, want holds the result as
  // written here, otherwise the shadow stack supplies it.
  typedef struct packed {
    mts_pkg::cmd_t    beat;
    logic             check_typed;
    mts_pkg::result_t want;
  } stim_row_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             start;
  mts_pkg::cmd_t    cmd;
  logic             busy;
  logic             done;
  mts_pkg::result_t result;

  // Shadow copy of the stack, bottom at index 0.
  logic signed [mts_pkg::VAL_W-1:0] shadow_stack [STACK_DEPTH];
  int                               shadow_count;
  int                               deepest_seen;

  mts_pkg::result_t pending_results [$];
  stim_row_t        directed_rows [23];

  int err_count;
  int n_items;
  int n_checked;
  int n_pop_max;
  int n_full_flags;
  int n_empty_flags;
  int cycle_count;

  max_tracking_stack_unit #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_top (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done),
    .result(result)
  );

  always #1 clk = ~clk;

  // Slot of the largest entry; on a tie keep the one nearest the top.
  function automatic int top_max_slot();
    int best;
    best = shadow_count - 1;
    for (int i = shadow_count - 2; i >= 0; i--) begin
      if (shadow_stack[i] > shadow_stack[best]) best = i;
    end
    return best;
  endfunction

  // Apply one request to the shadow stack and return the result it produces.
  function automatic mts_pkg::result_t stack_apply(input mts_pkg::cmd_t c);
    mts_pkg::result_t r;
    int               hit;
    r = '0;
    r.status = mts_pkg::STAT_OK;
    case (c.req_type)
      mts_pkg::REQ_PUSH: begin
        if (shadow_count >= STACK_DEPTH) begin
          r.status = mts_pkg::STAT_FULL;
        end else begin
          shadow_stack[shadow_count] = c.push_value;
          shadow_count++;
        end
      end
      mts_pkg::REQ_POP: begin
        if (shadow_count == 0) begin
          r.status = mts_pkg::STAT_EMPTY;
        end else begin
          shadow_count--;
          r.removed_value = shadow_stack[shadow_count];
        end
      end
      mts_pkg::REQ_POP_MAX: begin
        if (shadow_count == 0) begin
          r.status = mts_pkg::STAT_EMPTY;
        end else begin
          hit = top_max_slot();
          r.removed_value = shadow_stack[hit];
          // Close the gap: everything above the removed entry drops one slot.
          for (int j = hit; j < shadow_count - 1; j++) shadow_stack[j] = shadow_stack[j + 1];
          shadow_count--;
        end
      end
      default: ;
    endcase
    if (shadow_count > 0) begin
      r.top_value = shadow_stack[shadow_count - 1];
      r.max_value = shadow_stack[top_max_slot()];
    end
    r.occupancy = mts_pkg::OCC_W'(shadow_count);
    r.is_empty  = (shadow_count == 0);
    if (shadow_count > deepest_seen) deepest_seen = shadow_count;
    return r;
  endfunction

  // Values: half full-range, with a heavy share of a narrow band so that
  // ties on the maximum come up often, plus the two extremes.
  function automatic logic signed [mts_pkg::VAL_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return POS_LIMIT;
      1:       return NEG_LIMIT;
      2, 3, 4: return 32'($urandom_range(0, 8)) - 32'd4;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [1:0] pick_req(input traffic_mix_t mix);
    int r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  return r < 85 ? mts_pkg::REQ_PUSH : r < 90 ? mts_pkg::REQ_POP :
                        r < 97 ? mts_pkg::REQ_POP_MAX : mts_pkg::REQ_QUERY;
      MIX_DRAIN: return r < 15 ? mts_pkg::REQ_PUSH : r < 50 ? mts_pkg::REQ_POP :
                        r < 92 ? mts_pkg::REQ_POP_MAX : mts_pkg::REQ_QUERY;
      default:   return r < 45 ? mts_pkg::REQ_PUSH : r < 65 ? mts_pkg::REQ_POP :
                        r < 90 ? mts_pkg::REQ_POP_MAX : mts_pkg::REQ_QUERY;
    endcase
  endfunction

  // Present one command beat and hold it until the unit takes it, then
  // queue the result it should produce. start stays high on return so a
  // back-to-back beat never drops it.
  task automatic send_beat(input mts_pkg::cmd_t c, input logic check_typed,
                           input mts_pkg::result_t want);
    mts_pkg::result_t predicted;
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = stack_apply(c);
    pending_results.insert(pending_results.size(), check_typed ? want : predicted);
    n_items++;
    if (c.req_type == mts_pkg::REQ_POP_MAX) n_pop_max++;
    if (predicted.status == mts_pkg::STAT_FULL) n_full_flags++;
    if (predicted.status == mts_pkg::STAT_EMPTY) n_empty_flags++;
  endtask

  // Drop start for a random pause: mostly none or short, now and then long.
  task automatic idle_gap();
    int r;
    int gap;
    r = $urandom_range(0, 99);
    gap = r < 55 ? 0 : r < 90 ? $urandom_range(1, 3) : $urandom_range(8, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic compare_field(input string fname, input logic [mts_pkg::VAL_W-1:0] want,
                               input logic [mts_pkg::VAL_W-1:0] got);
    if (want !== got) begin
      err_count++;
      if (err_count <= REPORT_LIMIT)
        $display("%0t: result %0d field %s: expected %h, got %h",
                 $realtime, n_checked, fname, want, got);
    end
  endtask

  // Result side: the unit cannot be stalled, so take every done beat as it
  // comes and match it against the oldest pending expectation.
  always @(posedge clk) begin : check_results
    mts_pkg::result_t want;
    if (!rst && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        err_count++;
        if (err_count <= REPORT_LIMIT)
          $display("%0t: result beat with nothing pending: %h", $realtime, result);
      end else begin
        want = pending_results.pop_front();
        compare_field("removed_value", want.removed_value, result.removed_value);
        compare_field("top_value", want.top_value, result.top_value);
        compare_field("max_value", want.max_value, result.max_value);
        compare_field("occupancy", mts_pkg::VAL_W'(want.occupancy),
                      mts_pkg::VAL_W'(result.occupancy));
        compare_field("is_empty", mts_pkg::VAL_W'(want.is_empty),
                      mts_pkg::VAL_W'(result.is_empty));
        compare_field("status", mts_pkg::VAL_W'(want.status),
                      mts_pkg::VAL_W'(result.status));
      end
      n_checked++;
    end
  end

  // Hard stop in case the unit hangs or drops a result.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still pending",
             cycle_count, pending_results.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    mts_pkg::cmd_t c;
    traffic_mix_t  mix;
    int            run_len;
    logic          no_gaps;

    rst   = 1'b1;
    start = 1'b0;
    cmd   = '0;
    shadow_count  = 0;
    deepest_seen  = 0;
    err_count     = 0;
    n_items       = 0;
    n_checked     = 0;
    n_pop_max     = 0;
    n_full_flags  = 0;
    n_empty_flags = 0;

    // Directed beats: empty-stack removals, both value extremes, a tied
    // maximum just below the top and one buried below, then a tie among negatives.
    directed_rows = '{
      '{'{mts_pkg::REQ_POP,     32'sd0},        1'b1, EMPTY_FLAGGED},
      '{'{mts_pkg::REQ_POP_MAX, 32'h1234_5678}, 1'b1, EMPTY_FLAGGED},
      '{'{mts_pkg::REQ_QUERY,   -32'sd1},       1'b1, EMPTY_QUIET},
      '{'{mts_pkg::REQ_PUSH,    POS_LIMIT},     1'b1,
        '{32'sd0, POS_LIMIT, POS_LIMIT, 7'd1, 1'b0, mts_pkg::STAT_OK}},
      '{'{mts_pkg::REQ_PUSH,    NEG_LIMIT},     1'b1,
        '{32'sd0, NEG_LIMIT, POS_LIMIT, 7'd2, 1'b0, mts_pkg::STAT_OK}},
      '{'{mts_pkg::REQ_PUSH,    -32'sd1},       1'b0, '0},
      '{'{mts_pkg::REQ_PUSH,    POS_LIMIT},     1'b0, '0},
      '{'{mts_pkg::REQ_PUSH,    32'sd0},        1'b0, '0},
      '{'{mts_pkg::REQ_QUERY,   32'sd0},        1'b0, '0},
      '{'{mts_pkg::REQ_POP_MAX, 32'sd0},        1'b0, '0},
      '{'{mts_pkg::REQ_POP_MAX, 32'sd0},        1'b0, '0},
      '{'{mts_pkg::REQ_POP,     32'sd0},        1'b0, '0},
      '{'{mts_pkg::REQ_POP_MAX, 32'sd0},        1'b0, '0},
      '{'{mts_pkg::REQ_POP,     32'sd0},        1'b0, '0},
      '{'{mts_pkg::REQ_POP,     POS_LIMIT},     1'b1, EMPTY_FLAGGED},
      '{'{mts_pkg::REQ_PUSH,    -32'sd5},       1'b0, '0},
      '{'{mts_pkg::REQ_PUSH,    -32'sd5},       1'b0, '0},
      '{'{mts_pkg::REQ_PUSH,    -32'sd7},       1'b0, '0},
      '{'{mts_pkg::REQ_POP_MAX, 32'sd0},        1'b0, '0},
      '{'{mts_pkg::REQ_QUERY,   NEG_LIMIT},     1'b0, '0},
      '{'{mts_pkg::REQ_POP_MAX, 32'sd0},        1'b0, '0},
      '{'{mts_pkg::REQ_POP_MAX, 32'sd0},        1'b0, '0},
      '{'{mts_pkg::REQ_POP_MAX, 32'sd0},        1'b1, EMPTY_FLAGGED}
    };

    // Hold reset from the start, then release it once.
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_beat(directed_rows[i].beat, directed_rows[i].check_typed, directed_rows[i].want);
      idle_gap();
    end

    // Random part: runs of one traffic mix so the stack climbs to full and
    // drains to empty repeatedly; some runs keep start high throughout.
    while (n_items < ITEM_TARGET) begin
      mix     = traffic_mix_t'($urandom_range(0, 2));
      run_len = $urandom_range(20, 120);
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < run_len && n_items < ITEM_TARGET; k++) begin
        c.req_type   = pick_req(mix);
        c.push_value = rand_value();
        send_beat(c, 1'b0, '0);
        if (!no_gaps) idle_gap();
      end
    end
    start <= 1'b0;

    // Drain: wait for every pending result, then give a stray beat time to show.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("sent %0d requests (%0d pop-max), checked %0d results, deepest stack %0d",
             n_items, n_pop_max, n_checked, deepest_seen);
    $display("flagged %0d pushes onto a full stack and %0d removals from an empty one",
             n_full_flags, n_empty_flags);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", err_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/mts_pkg.sv
rtl/mts_cell.sv
rtl/max_tracking_stack_unit.sv
rtl/mts_checker.sv
tb/tb_max_tracking_stack_unit.sv
